// ===== rtl/kmc_pkg.sv =====
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared constants for the 2-D k-means clustering core: default sizes,
// request and response codes, configuration register map and reset values.
// ----------------------------------------------------------------------------
package kmc_pkg;

  // default sizes
  localparam int MAX_POINTS_DEF   = 128;
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int COORD_BITS_DEF   = 16;

  // request codes
  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RUN     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_INVALID = 2'd3;

  // response kinds
  localparam logic RESP_RUN   = 1'b0;
  localparam logic RESP_LABEL = 1'b1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 2'd2;

  // register widths and reset values
  localparam int CLUSTER_CNT_W = 5;
  localparam int POINT_CNT_W   = 8;
  localparam int ITER_W        = 8;
  localparam int MEMBER_OUT_W  = 8;
  localparam logic [CLUSTER_CNT_W-1:0] CLUSTER_COUNT_RST   = 5'd2;
  localparam logic [POINT_CNT_W-1:0]   POINT_COUNT_RST     = 8'd1;
  localparam logic [ITER_W-1:0]        ITERATION_COUNT_RST = 8'd10;

endpackage

// ===== rtl/kmc_sqdist.sv =====
// ----------------------------------------------------------------------------
// kmc_sqdist
// Squared Euclidean distance between a point and a centroid, using one
// shared multiplier for dx*dx and dy*dy over consecutive cycles.
// ----------------------------------------------------------------------------
module kmc_sqdist #(
  parameter int COORD_BITS = kmc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  output logic                         done_o,
  output logic [2*COORD_BITS:0]        dist_o
);

  localparam int CW = COORD_BITS;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_MX,
    SQ_MY,
    SQ_ADD
  } sq_state_e;

  sq_state_e         state_q;
  logic [CW-1:0]     dx_q, dy_q;
  logic [2*CW-1:0]   prod_q, acc_q;
  logic [2*CW:0]     dist_q;
  logic              done_q;
  logic [CW-1:0]     mul_op;
  logic signed [CW:0] diff_x, diff_y;
  logic signed [CW:0] mag_x, mag_y;

  always_comb begin
    diff_x = {cx_i[CW-1], cx_i} - {px_i[CW-1], px_i};
    diff_y = {cy_i[CW-1], cy_i} - {py_i[CW-1], py_i};
    mag_x  = diff_x[CW] ? -diff_x : diff_x;
    mag_y  = diff_y[CW] ? -diff_y : diff_y;
    mul_op = (state_q == SQ_MY) ? dy_q : dx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      dx_q    <= '0;
      dy_q    <= '0;
      prod_q  <= '0;
      acc_q   <= '0;
      dist_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == SQ_ADD);
      prod_q <= mul_op * mul_op;
      unique case (state_q)
        SQ_IDLE: begin
          if (start_i) begin
            dx_q    <= mag_x[CW-1:0];
            dy_q    <= mag_y[CW-1:0];
            state_q <= SQ_MX;
          end
        end
        SQ_MX: state_q <= SQ_MY;
        SQ_MY: begin
          acc_q   <= prod_q;
          state_q <= SQ_ADD;
        end
        SQ_ADD: begin
          dist_q  <= {1'b0, acc_q} + {1'b0, prod_q};
          state_q <= SQ_IDLE;
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign dist_o = dist_q;

endmodule

// ===== rtl/kmc_divider.sv =====
// ----------------------------------------------------------------------------
// kmc_divider
// Restoring divider, one quotient bit per cycle. Signed dividend over an
// unsigned member count, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module kmc_divider #(
  parameter int SUM_W = 24,
  parameter int DIV_W = 8,
  parameter int QUO_W = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [QUO_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] acc_q;
  logic [DIV_W-1:0] rem_q, div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q, neg_q;
  logic [DIV_W:0]   trial, trial_sub;
  logic             qbit;
  logic signed [SUM_W-1:0] mag_in;

  always_comb begin
    mag_in    = dividend_i[SUM_W-1] ? -dividend_i : dividend_i;
    trial     = {rem_q, acc_q[SUM_W-1]};
    trial_sub = trial - {1'b0, div_q};
    qbit      = (trial >= {1'b0, div_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(SUM_W - 1));
      if (start_i) begin
        acc_q  <= mag_in;
        rem_q  <= '0;
        div_q  <= divisor_i;
        neg_q  <= dividend_i[SUM_W-1];
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= qbit ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
        acc_q <= {acc_q[SUM_W-2:0], qbit};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(acc_q[QUO_W-1:0]) : $signed(acc_q[QUO_W-1:0]);

endmodule

// ===== rtl/kmeans_2d_clustering_core.sv =====
// ----------------------------------------------------------------------------
// kmeans_2d_clustering_core
// Load: no result. Label read: label read from memory, then registered in the
// output register once free. Run: seed k centroids, then per iteration clear
// k sums, assign n points, update k centroids; send k results. Distances one
// at a time through the shared multiplier, one quotient bit per cycle in the
// divider. Input stalls in a run and while labels are cleared after reset.
// ----------------------------------------------------------------------------
module kmeans_2d_clustering_core #(
  parameter int MAX_POINTS   = kmc_pkg::MAX_POINTS_DEF,
  parameter int MAX_CLUSTERS = kmc_pkg::MAX_CLUSTERS_DEF,
  parameter int COORD_BITS   = kmc_pkg::COORD_BITS_DEF,
  localparam int PW = $clog2(MAX_POINTS),
  localparam int KW = $clog2(MAX_CLUSTERS)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [kmc_pkg::REQ_W-1:0]       req_type_i,
  input  logic [PW-1:0]                   point_index_i,
  input  logic signed [COORD_BITS-1:0]    coord_x_i,
  input  logic signed [COORD_BITS-1:0]    coord_y_i,
  // response channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            resp_kind_o,
  output logic [KW-1:0]                   cluster_index_o,
  output logic signed [COORD_BITS-1:0]    centroid_x_o,
  output logic signed [COORD_BITS-1:0]    centroid_y_o,
  output logic [kmc_pkg::MEMBER_OUT_W-1:0] member_count_o,
  output logic [KW-1:0]                   point_label_o,
  output logic                            last_of_run_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kmc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kmc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int KC_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int SUM_W = COORD_BITS + CNT_W;
  localparam int DD_W  = 2 * COORD_BITS + 1;
  localparam int IT_W  = kmc_pkg::ITER_W;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LBL_RD,
    ST_LBL_SEND,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_ITER_CLR,
    ST_ASG_PRD,
    ST_ASG_CRD,
    ST_ASG_GO,
    ST_ASG_WAIT,
    ST_ASG_SRD,
    ST_ASG_SWR,
    ST_UPD_RD,
    ST_UPD_CHK,
    ST_UPD_DX,
    ST_UPD_DY,
    ST_UPD_NEXT,
    ST_OUT_RD,
    ST_OUT_SEND
  } state_e;

  // configuration registers
  logic [kmc_pkg::CLUSTER_CNT_W-1:0] cluster_count_q;
  logic [kmc_pkg::POINT_CNT_W-1:0]   point_count_q;
  logic [IT_W-1:0]                   iteration_count_q;

  // sequencer
  state_e            state_q;
  logic [PW-1:0]     clr_q;
  logic [CNT_W-1:0]  i_q, n_q;
  logic [KC_W-1:0]   j_q, k_q;
  logic [IT_W-1:0]   it_q;
  logic [KW-1:0]     best_q;
  logic [DD_W-1:0]   best_d_q;
  logic              oor_q;
  logic signed [COORD_BITS-1:0] qx_q;

  // output register
  logic                          out_valid_q;
  logic                          resp_kind_q;
  logic [KW-1:0]                 cluster_index_q;
  logic signed [COORD_BITS-1:0]  centroid_x_q, centroid_y_q;
  logic [kmc_pkg::MEMBER_OUT_W-1:0] member_count_q;
  logic [KW-1:0]                 point_label_q;
  logic                          last_q;

  // memories
  logic signed [COORD_BITS-1:0] px_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] py_mem [MAX_POINTS];
  logic [KW-1:0]                lbl_mem [MAX_POINTS];
  logic signed [COORD_BITS-1:0] cx_mem [MAX_CLUSTERS];
  logic signed [COORD_BITS-1:0] cy_mem [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]      sx_mem [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]      sy_mem [MAX_CLUSTERS];
  logic [CNT_W-1:0]             cnt_mem [MAX_CLUSTERS];

  logic signed [COORD_BITS-1:0] px_rd_q, py_rd_q, cx_rd_q, cy_rd_q;
  logic signed [SUM_W-1:0]      sx_rd_q, sy_rd_q;
  logic [CNT_W-1:0]             cnt_rd_q;
  logic [KW-1:0]                lbl_rd_q;

  // control
  logic             in_acc, out_free, out_load;
  logic [PW-1:0]    pt_addr;
  logic [KW-1:0]    ca;
  logic             i_last, j_last, it_last;
  int               n_int, k_int;
  logic [CNT_W-1:0] n_eff;
  logic [KC_W-1:0]  k_eff;
  logic             pt_we, lbl_we, cen_we, sum_we;
  logic [PW-1:0]    lbl_waddr;
  logic [KW-1:0]    lbl_wdata;
  logic signed [COORD_BITS-1:0] cen_wx, cen_wy;
  logic signed [SUM_W-1:0]      sum_wx, sum_wy;
  logic [CNT_W-1:0]             cnt_wdata;

  // shared units
  logic             sqd_start, sqd_done;
  logic [DD_W-1:0]  sqd_dist;
  logic             div_start, div_done;
  logic signed [SUM_W-1:0]      div_dividend;
  logic signed [COORD_BITS-1:0] div_quot;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = ((state_q == ST_LBL_SEND) || (state_q == ST_OUT_SEND)) && out_free;
  assign cfg_ready_o = 1'b1;

  // effective point and cluster counts
  always_comb begin
    n_int = int'(point_count_q);
    if (n_int < 1) n_int = 1;
    if (n_int > MAX_POINTS) n_int = MAX_POINTS;
    k_int = int'(cluster_count_q);
    if (k_int < 1) k_int = 1;
    if (k_int > MAX_CLUSTERS) k_int = MAX_CLUSTERS;
    if (k_int > n_int) k_int = n_int;
    n_eff = CNT_W'(n_int);
    k_eff = KC_W'(k_int);
  end

  assign i_last  = ((i_q + CNT_W'(1)) == n_q);
  assign j_last  = ((j_q + KC_W'(1)) == k_q);
  assign it_last = ((it_q + IT_W'(1)) == iteration_count_q);

  always_comb begin
    pt_addr = (state_q == ST_SEED_RD || state_q == ST_SEED_WR) ? PW'(j_q) : i_q[PW-1:0];
    ca      = (state_q == ST_ASG_SRD || state_q == ST_ASG_SWR) ? best_q : j_q[KW-1:0];
  end

  // memory write controls
  always_comb begin
    pt_we     = in_acc && (req_type_i == kmc_pkg::REQ_LOAD)
                && (int'(point_index_i) < MAX_POINTS);
    lbl_we    = (state_q == ST_CLEAR) || (state_q == ST_ASG_SRD);
    lbl_waddr = (state_q == ST_CLEAR) ? clr_q : i_q[PW-1:0];
    lbl_wdata = (state_q == ST_CLEAR) ? '0 : best_q;
    cen_we    = (state_q == ST_SEED_WR) || (state_q == ST_UPD_DY && div_done);
    cen_wx    = (state_q == ST_SEED_WR) ? px_rd_q : qx_q;
    cen_wy    = (state_q == ST_SEED_WR) ? py_rd_q : div_quot;
    sum_we    = (state_q == ST_SEED_WR) || (state_q == ST_ITER_CLR)
                || (state_q == ST_ASG_SWR);
    if (state_q == ST_ASG_SWR) begin
      sum_wx    = sx_rd_q + SUM_W'(px_rd_q);
      sum_wy    = sy_rd_q + SUM_W'(py_rd_q);
      cnt_wdata = cnt_rd_q + CNT_W'(1);
    end else begin
      sum_wx    = '0;
      sum_wy    = '0;
      cnt_wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      px_mem[point_index_i] <= coord_x_i;
      py_mem[point_index_i] <= coord_y_i;
    end
    px_rd_q <= px_mem[pt_addr];
    py_rd_q <= py_mem[pt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lbl_we) begin
      lbl_mem[lbl_waddr] <= lbl_wdata;
    end
    lbl_rd_q <= lbl_mem[i_q[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cen_we) begin
      cx_mem[ca] <= cen_wx;
      cy_mem[ca] <= cen_wy;
    end
    cx_rd_q <= cx_mem[ca];
    cy_rd_q <= cy_mem[ca];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sx_mem[ca]  <= sum_wx;
      sy_mem[ca]  <= sum_wy;
      cnt_mem[ca] <= cnt_wdata;
    end
    sx_rd_q  <= sx_mem[ca];
    sy_rd_q  <= sy_mem[ca];
    cnt_rd_q <= cnt_mem[ca];
  end

  // shared unit handshakes
  assign sqd_start    = (state_q == ST_ASG_GO);
  assign div_start    = ((state_q == ST_UPD_CHK) && (cnt_rd_q != '0))
                        || ((state_q == ST_UPD_DX) && div_done);
  assign div_dividend = (state_q == ST_UPD_CHK) ? sx_rd_q : sy_rd_q;

  kmc_sqdist #(
    .COORD_BITS(COORD_BITS)
  ) u_sqdist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqd_start),
    .px_i   (px_rd_q),
    .py_i   (py_rd_q),
    .cx_i   (cx_rd_q),
    .cy_i   (cy_rd_q),
    .done_o (sqd_done),
    .dist_o (sqd_dist)
  );

  kmc_divider #(
    .SUM_W(SUM_W),
    .DIV_W(CNT_W),
    .QUO_W(COORD_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (cnt_rd_q),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_count_q   <= kmc_pkg::CLUSTER_COUNT_RST;
      point_count_q     <= kmc_pkg::POINT_COUNT_RST;
      iteration_count_q <= kmc_pkg::ITERATION_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kmc_pkg::REG_CLUSTER_COUNT:
          cluster_count_q <= cfg_data_i[kmc_pkg::CLUSTER_CNT_W-1:0];
        kmc_pkg::REG_POINT_COUNT:
          point_count_q <= cfg_data_i[kmc_pkg::POINT_CNT_W-1:0];
        kmc_pkg::REG_ITERATION_COUNT:
          iteration_count_q <= cfg_data_i[IT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_q           <= '0;
      i_q             <= '0;
      n_q             <= '0;
      j_q             <= '0;
      k_q             <= '0;
      it_q            <= '0;
      best_q          <= '0;
      best_d_q        <= '0;
      oor_q           <= 1'b0;
      qx_q            <= '0;
      out_valid_q     <= 1'b0;
      resp_kind_q     <= kmc_pkg::RESP_RUN;
      cluster_index_q <= '0;
      centroid_x_q    <= '0;
      centroid_y_q    <= '0;
      member_count_q  <= '0;
      point_label_q   <= '0;
      last_q          <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + PW'(1);
          if (int'(clr_q) == MAX_POINTS - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            priority if (req_type_i == kmc_pkg::REQ_RUN) begin
              n_q     <= n_eff;
              k_q     <= k_eff;
              j_q     <= '0;
              it_q    <= '0;
              state_q <= ST_SEED_RD;
            end else if (req_type_i == kmc_pkg::REQ_READ) begin
              i_q     <= CNT_W'(point_index_i);
              oor_q   <= (int'(point_index_i) >= MAX_POINTS);
              state_q <= ST_LBL_RD;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_LBL_RD: state_q <= ST_LBL_SEND;
        ST_LBL_SEND: begin
          if (out_free) begin
            resp_kind_q     <= kmc_pkg::RESP_LABEL;
            cluster_index_q <= '0;
            centroid_x_q    <= '0;
            centroid_y_q    <= '0;
            member_count_q  <= '0;
            point_label_q   <= oor_q ? '0 : lbl_rd_q;
            last_q          <= 1'b1;
            state_q         <= ST_IDLE;
          end
        end
        ST_SEED_RD: state_q <= ST_SEED_WR;
        ST_SEED_WR: begin
          if (j_last) begin
            j_q     <= '0;
            state_q <= (iteration_count_q == '0) ? ST_OUT_RD : ST_ITER_CLR;
          end else begin
            j_q     <= j_q + KC_W'(1);
            state_q <= ST_SEED_RD;
          end
        end
        ST_ITER_CLR: begin
          if (j_last) begin
            j_q     <= '0;
            i_q     <= '0;
            state_q <= ST_ASG_PRD;
          end else begin
            j_q <= j_q + KC_W'(1);
          end
        end
        ST_ASG_PRD: begin
          j_q     <= '0;
          state_q <= ST_ASG_CRD;
        end
        ST_ASG_CRD: state_q <= ST_ASG_GO;
        ST_ASG_GO:  state_q <= ST_ASG_WAIT;
        ST_ASG_WAIT: begin
          if (sqd_done) begin
            // strict compare keeps the lowest index on ties
            if (j_q == '0 || sqd_dist < best_d_q) begin
              best_q   <= j_q[KW-1:0];
              best_d_q <= sqd_dist;
            end
            if (j_last) begin
              state_q <= ST_ASG_SRD;
            end else begin
              j_q     <= j_q + KC_W'(1);
              state_q <= ST_ASG_CRD;
            end
          end
        end
        ST_ASG_SRD: state_q <= ST_ASG_SWR;
        ST_ASG_SWR: begin
          if (i_last) begin
            j_q     <= '0;
            state_q <= ST_UPD_RD;
          end else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= ST_ASG_PRD;
          end
        end
        ST_UPD_RD: state_q <= ST_UPD_CHK;
        ST_UPD_CHK: begin
          // empty cluster keeps its centroid
          state_q <= (cnt_rd_q == '0) ? ST_UPD_NEXT : ST_UPD_DX;
        end
        ST_UPD_DX: begin
          if (div_done) begin
            qx_q    <= div_quot;
            state_q <= ST_UPD_DY;
          end
        end
        ST_UPD_DY: begin
          if (div_done) begin
            state_q <= ST_UPD_NEXT;
          end
        end
        ST_UPD_NEXT: begin
          if (j_last) begin
            j_q <= '0;
            if (it_last) begin
              state_q <= ST_OUT_RD;
            end else begin
              it_q    <= it_q + IT_W'(1);
              state_q <= ST_ITER_CLR;
            end
          end else begin
            j_q     <= j_q + KC_W'(1);
            state_q <= ST_UPD_RD;
          end
        end
        ST_OUT_RD: state_q <= ST_OUT_SEND;
        ST_OUT_SEND: begin
          if (out_free) begin
            resp_kind_q     <= kmc_pkg::RESP_RUN;
            cluster_index_q <= j_q[KW-1:0];
            centroid_x_q    <= cx_rd_q;
            centroid_y_q    <= cy_rd_q;
            member_count_q  <= kmc_pkg::MEMBER_OUT_W'(cnt_rd_q);
            point_label_q   <= '0;
            last_q          <= j_last;
            if (j_last) begin
              state_q <= ST_IDLE;
            end else begin
              j_q     <= j_q + KC_W'(1);
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign resp_kind_o     = resp_kind_q;
  assign cluster_index_o = cluster_index_q;
  assign centroid_x_o    = centroid_x_q;
  assign centroid_y_o    = centroid_y_q;
  assign member_count_o  = member_count_q;
  assign point_label_o   = point_label_q;
  assign last_of_run_o   = last_q;

  // assertions
  a_best_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ASG_SWR) |-> (KC_W'(best_q) < k_q))
    else $error("winning cluster beyond cluster count");

  a_run_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && resp_kind_q == kmc_pkg::RESP_RUN) |-> (KC_W'(cluster_index_q) < k_q))
    else $error("run result for cluster beyond cluster count");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_UPD_DX || state_q == ST_UPD_DY))
    else $error("divider finished outside the update phase");

  a_sqd_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqd_done |-> (state_q == ST_ASG_WAIT))
    else $error("distance finished outside the assign phase");

  a_k_le_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED_WR) |-> (k_q != '0 && CNT_W'(k_q) <= n_q))
    else $error("cluster count not within point count");

endmodule
